// ===== src/icph_pkg.sv =====
// icph_pkg: shared constants, register indexes and ones'-complement helpers
// for the internet checksum block with pseudo-header
// no dependencies
package icph_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_USE_PSEUDO = 2'd0,
    REG_SRC_ADDR   = 2'd1,
    REG_DST_ADDR   = 2'd2,
    REG_PROTOCOL   = 2'd3
  } cfg_reg_e;

  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AccW   = 19;  // room for eight 16-bit terms
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [WordW-1:0] WordMask = 16'hFFFF;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AccW-1:0]  acc_t;

  // widen a 16-bit word to the accumulator width
  function automatic acc_t widen(input word_t w);
    widen = {{(AccW-WordW){1'b0}}, w};
  endfunction

  // fold a plain sum of up to eight words to a 16-bit ones'-complement sum;
  // two end-around passes always suffice and zero stays zero
  function automatic word_t fold(input acc_t s);
    logic [WordW:0] t;
    t    = {1'b0, s[WordW-1:0]} + {{(WordW+1-(AccW-WordW)){1'b0}}, s[AccW-1:WordW]};
    fold = t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
  endfunction

endpackage

// ===== src/internet_checksum_pseudo_header.sv =====
// internet_checksum_pseudo_header: byte-serial internet checksum with an
// optional ipv4 pseudo-header term, stream in and stream out
// depends on icph_pkg
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-------------------------------
//  s_axis    | in  | tvalid / tready         | tdata: data_byte, tlast: last_byte
//  m_axis    | out | tvalid / tready         | tdata: checksum, tuser: too_long
//  cfg       | in  | cfg_we_i (no handshake) | cfg_addr_i, cfg_wdata_i
//
// one byte is taken per cycle while the output slot is free or being drained;
// the result of a packet appears in the cycle after its last byte transfer,
// set by the single sum-and-fold stage before the output register.
// rst_ni clears the running sum, byte count, flag, config and output valid.
// a stalled result holds the output register; input is taken again in the
// cycle the result is taken.
module internet_checksum_pseudo_header
  import icph_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // byte stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tlast_i,   // last_byte
  // checksum out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [WordW-1:0]    m_axis_tdata_o,   // [15:0] checksum
  output logic                m_axis_tuser_o    // [0] too_long
);

  // config registers
  logic                use_ph_q;
  logic [CfgW-1:0]     src_addr_q;
  logic [CfgW-1:0]     dst_addr_q;
  logic [ByteW-1:0]    protocol_q;

  // per-packet state
  word_t               sum_q, sum_d;
  word_t               count_q, count_d;
  logic                ovf_q, ovf_d;

  // output register
  logic                out_valid_q, out_valid_d;
  word_t               out_csum_q, out_csum_d;
  logic                out_long_q, out_long_d;

  logic                in_xfer;
  word_t               term;
  word_t               count_inc;
  logic                ovf_next;
  acc_t                run_acc;
  acc_t                ph_acc;
  word_t               final_sum;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_ph_q   <= 1'b0;
      src_addr_q <= '0;
      dst_addr_q <= '0;
      protocol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_USE_PSEUDO: use_ph_q   <= cfg_wdata_i[0];
        REG_SRC_ADDR:   src_addr_q <= cfg_wdata_i;
        REG_DST_ADDR:   dst_addr_q <= cfg_wdata_i;
        REG_PROTOCOL:   protocol_q <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // input side accepts whenever the output slot is free or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // even offsets are the high half of a word, odd offsets the low half
  assign term      = count_q[0] ? {{(WordW-ByteW){1'b0}}, s_axis_tdata_i}
                                : {s_axis_tdata_i, {(WordW-ByteW){1'b0}}};
  assign count_inc = count_q + word_t'(1);
  assign ovf_next  = ovf_q || (count_q == WordMask);

  // running sum with the new byte
  assign run_acc = widen(sum_q) + widen(term);

  // pseudo-header terms, folded together with the packet sum on the last byte
  always_comb begin
    ph_acc = '0;
    if (use_ph_q) begin
      ph_acc = widen(src_addr_q[CfgW-1:WordW]) + widen(src_addr_q[WordW-1:0])
             + widen(dst_addr_q[CfgW-1:WordW]) + widen(dst_addr_q[WordW-1:0])
             + widen({{(WordW-ByteW){1'b0}}, protocol_q}) + widen(count_inc);
    end
  end

  assign final_sum = fold(run_acc + ph_acc);

  // next state of the packet accumulator and the output register
  always_comb begin
    sum_d       = sum_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_csum_d  = out_csum_q;
    out_long_d  = out_long_q;
    if (in_xfer) begin
      if (s_axis_tlast_i) begin
        sum_d       = '0;
        count_d     = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
        out_csum_d  = ~final_sum;
        out_long_d  = ovf_next;
      end else begin
        sum_d   = fold(run_acc);
        count_d = count_inc;
        ovf_d   = ovf_next;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_csum_q <= out_csum_d;
    out_long_q <= out_long_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_csum_q;
  assign m_axis_tuser_o  = out_long_q;

endmodule

// ===== src/icph_checker.sv =====
// icph_checker: port-level checks for internet_checksum_pseudo_header,
// attached by bind at the end of this file
// depends on icph_pkg
module icph_checker
  import icph_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                s_axis_tlast_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [WordW-1:0]    m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  // a last-byte transfer yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("no result after last byte");

  // a middle byte with nothing pending produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i && !m_axis_tvalid_o
    |=> !m_axis_tvalid_o)
    else $error("result without last byte");

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped under stall");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
    |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed under stall");

endmodule

bind internet_checksum_pseudo_header icph_checker u_icph_checker (.*);

// ===== tb/tb_internet_checksum_pseudo_header.sv =====
// tb_internet_checksum_pseudo_header: self-checking bench for the byte-serial
// internet checksum with optional ipv4 pseudo-header; directed, overlong and random packets
// depends on icph_pkg and internet_checksum_pseudo_header
module tb_internet_checksum_pseudo_header;
  import icph_pkg::*;

  // one expected checksum transfer
  typedef struct packed {
    word_t checksum;
    logic  too_long;
  } csum_result_t;

  // predicts checksums from accepted bytes and compares them with the output
  class checksum_scoreboard;
    logic         use_pseudo  = 1'b0;
    logic [31:0]  src_addr    = '0;
    logic [31:0]  dst_addr    = '0;
    logic [7:0]   proto       = '0;
    word_t        run_sum     = '0;
    word_t        byte_cnt    = '0;
    logic         len_wrapped = 1'b0;
    csum_result_t sums_due[$];
    int unsigned  errors      = 0;

    // 16-bit ones'-complement add with end-around carry
    function word_t ones_add(word_t a, word_t b);
      logic [WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
      case (idx)
        REG_USE_PSEUDO: use_pseudo = val[0];
        REG_SRC_ADDR:   src_addr   = val;
        REG_DST_ADDR:   dst_addr   = val;
        REG_PROTOCOL:   proto      = val[7:0];
        default: ;
      endcase
    endfunction

    // accepted input byte: even offsets are the high half of a word
    function void note_byte(logic [7:0] b, logic last);
      word_t        total;
      csum_result_t r;
      run_sum = ones_add(run_sum, byte_cnt[0] ? {8'd0, b} : {b, 8'd0});
      if (byte_cnt == WordMask) len_wrapped = 1'b1;
      byte_cnt = byte_cnt + 16'd1;
      if (last) begin
        total = run_sum;
        if (use_pseudo) begin
          total = ones_add(total, src_addr[31:16]);
          total = ones_add(total, src_addr[15:0]);
          total = ones_add(total, dst_addr[31:16]);
          total = ones_add(total, dst_addr[15:0]);
          total = ones_add(total, {8'd0, proto});
          total = ones_add(total, byte_cnt);
        end
        r.checksum = ~total;
        r.too_long = len_wrapped;
        sums_due.push_back(r);
        run_sum     = '0;
        byte_cnt    = '0;
        len_wrapped = 1'b0;
      end
    endfunction

    function void check_result(word_t cs, logic tl);
      csum_result_t e;
      if (sums_due.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual checksum %h too_long %b",
                 $time, cs, tl);
        errors++;
        return;
      end
      e = sums_due.pop_front();
      if (cs !== e.checksum) begin
        $display("%0t checksum mismatch: expected %h actual %h", $time, e.checksum, cs);
        errors++;
      end
      if (tl !== e.too_long) begin
        $display("%0t too_long mismatch: expected %b actual %b", $time, e.too_long, tl);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return sums_due.size();
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i      = '0;
  logic [CfgW-1:0]     cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i  = '0;   // [7:0] data_byte
  logic                s_axis_tlast_i  = 1'b0; // last_byte
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [WordW-1:0]    m_axis_tdata_o;         // [15:0] checksum
  logic                m_axis_tuser_o;         // [0] too_long

  checksum_scoreboard sb = new;
  bit                 gaps_on = 1'b1;
  logic [7:0]         pkt_buf[$];

  internet_checksum_pseudo_header uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: check each transfer, stall at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_axis_tready_i <= !gaps_on || ($urandom_range(0, 99) >= 26);
  end

  // one byte transfer, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, last);
  endtask

  task automatic send_buffer();
    foreach (pkt_buf[i]) send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
  endtask

  task automatic send_random_packet(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // hold the stream until every checksum is back, then let the pipe settle
  task automatic wait_results_done();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // upper bits of the narrow registers carry noise that must be ignored
  task automatic set_config(input logic use_ph, input logic [31:0] src,
                            input logic [31:0] dst, input logic [7:0] prot);
    put_reg(REG_USE_PSEUDO, {31'($urandom_range(0, 32'h7FFF_FFFF)), use_ph});
    put_reg(REG_SRC_ADDR, src);
    put_reg(REG_DST_ADDR, dst);
    put_reg(REG_PROTOCOL, {24'($urandom_range(0, 32'h00FF_FFFF)), prot});
    cfg_we_i <= 1'b0;
  endtask

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pkt_num;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, pseudo-header off: ones'-complement zero cases, carry, odd tail
    pkt_buf = '{8'hFF, 8'hFF};
    send_buffer();
    pkt_buf = '{8'h00};
    send_buffer();
    pkt_buf = '{8'h80};
    send_buffer();
    pkt_buf = '{8'hFF, 8'hFF, 8'h00, 8'h01};
    send_buffer();
    pkt_buf = '{8'h12, 8'h34, 8'h56};
    send_buffer();
    wait_results_done();

    // directed, pseudo-header at all-ones, all-zeros and a typical setting
    set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    pkt_buf = '{8'hFF};
    send_buffer();
    pkt_buf = '{8'h00, 8'h00};
    send_buffer();
    wait_results_done();
    set_config(1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00);
    pkt_buf = '{8'h00};
    send_buffer();
    wait_results_done();
    set_config(1'b1, 32'hC0A8_0001, 32'h0A00_0002, 8'h11);
    pkt_buf = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_buffer();
    wait_results_done();

    // length extremes with no gaps: just under, at and past the 16-bit count
    gaps_on = 1'b0;
    set_config(1'b1, $urandom, $urandom, 8'($urandom_range(0, 255)));
    send_random_packet(65535);
    send_random_packet(65536);
    send_random_packet(65536 + $urandom_range(1, 40));
    send_random_packet(3);
    wait_results_done();
    set_config(1'b0, $urandom, $urandom, 8'($urandom_range(0, 255)));
    send_random_packet(65536 + $urandom_range(1, 40));
    wait_results_done();

    // random packets under several settings, one phase without gaps
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = (ph != 3);
      set_config(ph == 0 ? 1'b0 : 1'($urandom_range(0, 1)), $urandom, $urandom,
                 8'($urandom_range(0, 255)));
      sent    = 0;
      pkt_num = 0;
      while (sent < 110) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        send_random_packet(len);
        sent += len;
        if (pkt_num == 0 || $urandom_range(0, 7) == 0) wait_results_done();
        pkt_num++;
      end
      wait_results_done();
    end

    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/icph_pkg.sv
src/internet_checksum_pseudo_header.sv
src/icph_checker.sv
tb/tb_internet_checksum_pseudo_header.sv
